/* sv/vpd_pkg.sv */
// vpd_pkg: shared types and constants for the vision packet deframer
// no dependencies; imported by vpd_frame, vpd_outbuf and the top level
package vpd_pkg;

  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'hAE;
  localparam logic [7:0] Trailer   = 8'hAC;
  localparam logic [7:0] NegXMark  = 8'hB2;
  localparam logic [7:0] NegYMark  = 8'hC2;

  localparam int unsigned StoreDepth = 10;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ResW       = 50;
  localparam int unsigned TdataOutW  = ((ResW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef struct packed {
    logic signed [8:0] delta_y;
    logic signed [8:0] delta_x;
    logic [15:0]       pos_y;
    logic [15:0]       pos_x;
  } res_t;

  function automatic logic signed [8:0] signed_mag9(input logic [7:0] mag, input logic neg);
    logic signed [8:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

endpackage

/* sv/vpd_frame.sv */
// vpd_frame: header hunt, payload capture, check byte test and decode hold
// depends on vpd_pkg
module vpd_frame #(
  parameter int unsigned PAYLOAD_BYTES = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          res_valid_o,
  output vpd_pkg::res_t res_o
);
  import vpd_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAYLOAD_BYTES - 1);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      store_q [StoreDepth];
  res_t            hold_q;

  logic last_byte;
  logic store_we;
  logic decode_en;

  assign last_byte = (idx_q == LastIdx);

  // next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (byte_valid_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == HdrFirst) phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          if (byte_i == HdrSecond) begin
            phase_d = PH_DATA;
            idx_d   = '0;
          end
        end
        PH_DATA: begin
          if (last_byte) begin
            idx_d   = '0;
            phase_d = (byte_i == Trailer) ? PH_TAIL : PH_HUNT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_TAIL: begin
          if (byte_i == Trailer) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // outputs
  always_comb begin
    store_we    = 1'b0;
    decode_en   = 1'b0;
    res_valid_o = 1'b0;
    case (phase_q)
      PH_DATA: begin
        store_we  = byte_valid_i && (idx_q < IdxW'(StoreDepth));
        decode_en = byte_valid_i && last_byte && (byte_i == Trailer);
      end
      PH_TAIL: begin
        res_valid_o = byte_valid_i && (byte_i == Trailer);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[idx_q[StoreIdxW-1:0]] <= byte_i;
    if (decode_en) begin
      hold_q.pos_x   <= {store_q[1], store_q[0]};
      hold_q.pos_y   <= {store_q[3], store_q[2]};
      hold_q.delta_x <= signed_mag9(store_q[4], store_q[8] == NegXMark);
      hold_q.delta_y <= signed_mag9(store_q[6], store_q[9] == NegYMark);
    end
  end

  assign res_o = hold_q;

endmodule

/* sv/vpd_outbuf.sv */
// vpd_outbuf: result register with one skid entry toward the output stream
// depends on vpd_pkg
module vpd_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vpd_pkg::res_t push_data_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vpd_pkg::res_t out_data_o
);
  import vpd_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop    = out_valid_q && out_ready_i;
  assign room_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/vision_packet_deframer.sv */
// vision_packet_deframer: one received byte per request, one decoded result per packet
// result: registered once the closing trailer byte request is accepted
// throughput: one byte per cycle; s_axis_tready drops only when both the
// result register and its skid entry hold undelivered results
// reset: asynchronous active low, parser back to hunting the first header, output empty
module vision_packet_deframer #(
  parameter int unsigned PAYLOAD_BYTES = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [15:0] pos_x, [31:16] pos_y, [40:32] delta_x,
                                      // [49:41] delta_y, [55:50] zero
);
  import vpd_pkg::*;

  logic byte_valid;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign byte_valid = s_axis_tvalid && s_axis_tready;

  vpd_frame #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vpd_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .room_o     (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {(TdataOutW - ResW)'(0), out_res};

endmodule

/* sv/vpd_checker.sv */
// vpd_checker: port level checks for the vision packet deframer, bound to the top level
// depends on vision_packet_deframer port list
module vpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a new result follows an accepted trailer byte
  a_rise_after_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'hAC))
    else $error("result without trailer request");

  // input back pressure only while results wait
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // deltas are negated bytes, never -256
  a_delta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[40:32] != 9'h100) && (m_axis_tdata[49:41] != 9'h100))
    else $error("delta out of range");

endmodule

bind vision_packet_deframer vpd_checker u_vpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
